FILE: rtl/bcpd_pkg.sv
`timescale 1ns / 1ps

package bcpd_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned IvlW   = TimeW + 1;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned BoundW = CfgW + 2;
  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 11;
  localparam int unsigned AddrW  = 4;

  localparam logic [CfgW-1:0]  TOL_RESET = 32'd10000000;
  localparam logic [CodeW-1:0] CODE_MAX  = 11'd1408;

  localparam logic [1:0] REG_TENS  = 2'd0;
  localparam logic [1:0] REG_UNITS = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;
  localparam logic [1:0] REG_TOL   = 2'd3;

  typedef struct packed {
    logic signed [BoundW-1:0] tens_lo;
    logic signed [BoundW-1:0] tens_hi;
    logic signed [BoundW-1:0] units_lo;
    logic signed [BoundW-1:0] units_hi;
    logic signed [BoundW-1:0] gap_lo;
    logic signed [BoundW-1:0] gap_hi;
    logic [CfgW-1:0]          end_gap;
  } bcpd_bounds_t;

endpackage

FILE: rtl/blink_code_pulse_decoder_unit.sv
`timescale 1ns / 1ps
// An edge beat is held in the input register; its result beat then leaves the output register.
// Throughput: one edge beat per cycle unless stalled, set by the single input register and compare stage.
// A stalled result only holds the input back when the next edge would also close a frame.
// Reset is asynchronous and active low; it clears the valid flags, the counts, the first-edge
// flag and the configuration registers, except the tolerance, which returns to ten million.

module blink_code_pulse_decoder_unit import bcpd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [CfgW-1:0]        pwdata,
  output logic [CfgW-1:0]        prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TimeW-1:0]       edge_time_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CodeW-1:0]       error_code_o,
  output logic [TimeW-1:0]       frame_start_o,
  output logic signed [IvlW-1:0] frame_end_o
);

  bcpd_bounds_t bounds;

  bcpd_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  bcpd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bounds_i      (bounds),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .edge_time_i   (edge_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .error_code_o  (error_code_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

FILE: rtl/bcpd_regs.sv
`timescale 1ns / 1ps

module bcpd_regs import bcpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output bcpd_bounds_t     bounds_o
);

  logic [CfgW-1:0] tens_q, units_q, gap_q, tol_q;
  logic [1:0]      reg_idx;
  logic            wr_en;
  bcpd_bounds_t    bounds_d, bounds_q, bounds_rst;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tens_q  <= '0;
      units_q <= '0;
      gap_q   <= '0;
      tol_q   <= TOL_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TENS:  tens_q  <= pwdata;
        REG_UNITS: units_q <= pwdata;
        REG_GAP:   gap_q   <= pwdata;
        REG_TOL:   tol_q   <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TENS:  prdata = tens_q;
      REG_UNITS: prdata = units_q;
      REG_GAP:   prdata = gap_q;
      REG_TOL:   prdata = tol_q;
      default:   prdata = '0;
    endcase
  end

  // A match needs lo < interval < hi, with lo = spacing - tol and hi = spacing + tol.
  always_comb begin
    bounds_d.tens_lo  = $signed({2'b00, tens_q})  - $signed({2'b00, tol_q});
    bounds_d.tens_hi  = $signed({2'b00, tens_q})  + $signed({2'b00, tol_q});
    bounds_d.units_lo = $signed({2'b00, units_q}) - $signed({2'b00, tol_q});
    bounds_d.units_hi = $signed({2'b00, units_q}) + $signed({2'b00, tol_q});
    bounds_d.gap_lo   = $signed({2'b00, gap_q})   - $signed({2'b00, tol_q});
    bounds_d.gap_hi   = $signed({2'b00, gap_q})   + $signed({2'b00, tol_q});
    bounds_d.end_gap  = gap_q;
  end

  always_comb begin
    bounds_rst.tens_lo  = -$signed({2'b00, TOL_RESET});
    bounds_rst.tens_hi  = $signed({2'b00, TOL_RESET});
    bounds_rst.units_lo = -$signed({2'b00, TOL_RESET});
    bounds_rst.units_hi = $signed({2'b00, TOL_RESET});
    bounds_rst.gap_lo   = -$signed({2'b00, TOL_RESET});
    bounds_rst.gap_hi   = $signed({2'b00, TOL_RESET});
    bounds_rst.end_gap  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= bounds_rst;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

FILE: rtl/bcpd_core.sv
`timescale 1ns / 1ps

module bcpd_core import bcpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bcpd_bounds_t            bounds_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TimeW-1:0]        edge_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CodeW-1:0]        error_code_o,
  output logic [TimeW-1:0]        frame_start_o,
  output logic signed [IvlW-1:0]  frame_end_o
);

  logic                   s1_valid_q;
  logic [TimeW-1:0]       s1_time_q;
  logic                   seen_first_q;
  logic [TimeW-1:0]       prev_edge_q;
  logic [TimeW-1:0]       frame_begin_q;
  logic [CountW-1:0]      tens_count_q, units_count_q;
  logic [CountW-1:0]      tens_count_d, units_count_d;
  logic                   out_valid_q;
  logic [CodeW-1:0]       error_code_q;
  logic [TimeW-1:0]       frame_start_q;
  logic signed [IvlW-1:0] frame_end_q;

  logic                   in_accept, s1_fire, s1_emit, out_busy;
  logic signed [IvlW-1:0] interval;
  logic signed [IvlW:0]   ivl_x;
  logic                   tens_hit, units_hit, gap_hit;
  logic [CountW-1:0]      tens_digit, units_digit;
  logic [CodeW-1:0]       code_d;
  logic signed [IvlW-1:0] frame_end_d;

  function automatic logic in_window(logic signed [IvlW:0] v,
                                     logic signed [BoundW-1:0] lo,
                                     logic signed [BoundW-1:0] hi);
    logic signed [IvlW:0] lo_x;
    logic signed [IvlW:0] hi_x;
    lo_x = {{(IvlW + 1 - BoundW){lo[BoundW-1]}}, lo};
    hi_x = {{(IvlW + 1 - BoundW){hi[BoundW-1]}}, hi};
    return (v > lo_x) && (v < hi_x);
  endfunction

  assign interval  = $signed({1'b0, s1_time_q}) - $signed({1'b0, prev_edge_q});
  assign ivl_x     = {interval[IvlW-1], interval};
  assign tens_hit  = in_window(ivl_x, bounds_i.tens_lo, bounds_i.tens_hi);
  assign units_hit = in_window(ivl_x, bounds_i.units_lo, bounds_i.units_hi);
  assign gap_hit   = in_window(ivl_x, bounds_i.gap_lo, bounds_i.gap_hi);

  assign s1_emit    = seen_first_q && gap_hit;
  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && s1_emit && out_busy;
  assign s1_fire    = s1_valid_q && !in_stall_o;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign tens_count_d  = (tens_hit && (tens_count_q != '1)) ?
                         tens_count_q + CountW'(1) : tens_count_q;
  assign units_count_d = (units_hit && (units_count_q != '1)) ?
                         units_count_q + CountW'(1) : units_count_q;

  assign tens_digit  = CountW'(({1'b0, tens_count_d} + 9'd1) >> 1);
  assign units_digit = CountW'(({1'b0, units_count_d} + 9'd1) >> 1);
  assign code_d      = ({tens_digit, 3'b000}) + CodeW'({tens_digit, 1'b0})
                       + CodeW'(units_digit);
  assign frame_end_d = $signed({1'b0, s1_time_q})
                       - $signed({{(IvlW - CfgW){1'b0}}, bounds_i.end_gap});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_time_q <= edge_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_first_q  <= 1'b0;
      prev_edge_q   <= '0;
      frame_begin_q <= '0;
      tens_count_q  <= '0;
      units_count_q <= '0;
    end else if (s1_fire) begin
      seen_first_q <= 1'b1;
      prev_edge_q  <= s1_time_q;
      if (!seen_first_q) begin
        frame_begin_q <= s1_time_q;
      end else if (s1_emit) begin
        frame_begin_q <= s1_time_q;
        tens_count_q  <= '0;
        units_count_q <= '0;
      end else begin
        tens_count_q  <= tens_count_d;
        units_count_q <= units_count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      error_code_q  <= code_d;
      frame_start_q <= frame_begin_q;
      frame_end_q   <= frame_end_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign error_code_o  = error_code_q;
  assign frame_start_o = frame_start_q;
  assign frame_end_o   = frame_end_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |-> !(s1_fire && s1_emit))
    else $error("Result register overwritten while stalled.");

  a_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_emit) |=> (tens_count_q == '0) && (units_count_q == '0))
    else $error("Counts not cleared after frame end.");

  a_first_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !seen_first_q) |=>
      (seen_first_q && !$rose(out_valid_q) && (frame_begin_q == $past(s1_time_q))))
    else $error("First edge handled wrongly.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (error_code_q <= CODE_MAX))
    else $error("Code out of range.");
`endif

endmodule
